// File: sv/rgd_pkg.sv
// rgd_pkg: shared widths, codes, dither pattern and configuration type
// for the RGB to 4-bit gray converter. Depends on nothing.
`default_nettype none

package rgd_pkg;

   localparam int COORD_WIDTH  = 12;
   localparam int RGB_WIDTH    = 24;
   localparam int GRAY_WIDTH   = 4;
   localparam int BYTE_WIDTH   = 8;
   localparam int THR_WIDTH    = 5;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 8;

   localparam logic [31:0] GRAY_MASK  = 32'h00f8_f8f8;
   localparam logic [31:0] GRAY_MUL   = 32'h0020_a040;
   localparam logic [31:0] GRAY_ROUND = 32'h0700_0000;

   localparam logic [GRAY_WIDTH-1:0] LEVEL_BLACK = 4'd0;
   localparam logic [GRAY_WIDTH-1:0] LEVEL_DARK  = 4'd5;
   localparam logic [GRAY_WIDTH-1:0] LEVEL_LIGHT = 4'd10;
   localparam logic [GRAY_WIDTH-1:0] LEVEL_WHITE = 4'd15;

   // ordered dither pattern, indexed [x & 3][y & 3]
   localparam logic [GRAY_WIDTH-1:0] DITHER_TAB [0:3][0:3] = '{
      '{4'd7,  4'd8,  4'd2,  4'd10},
      '{4'd12, 4'd4,  4'd14, 4'd6},
      '{4'd3,  4'd11, 4'd1,  4'd9},
      '{4'd15, 4'd7,  4'd13, 4'd5}
   };

   typedef enum logic [1:0] {
      MODE_PLAIN  = 2'd0,
      MODE_DITHER = 2'd1,
      MODE_THRESH = 2'd2,
      MODE_TONES  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_MODE      = 3'd0,
      CSR_BW_THR    = 3'd1,
      CSR_INVERT    = 3'd2,
      CSR_TONE_LOW  = 3'd3,
      CSR_TONE_MID  = 3'd4,
      CSR_TONE_HIGH = 3'd5,
      CSR_MIRROR_X  = 3'd6
   } csr_index_type;

   typedef struct packed {
      mode_type               mode;
      logic [THR_WIDTH-1:0]   mono_threshold;
      logic                   invert;
      logic [THR_WIDTH-1:0]   tone_low;
      logic [THR_WIDTH-1:0]   tone_mid;
      logic [THR_WIDTH-1:0]   tone_high;
      logic                   mirror_x;
   } cfg_type;

endpackage

`default_nettype wire

// File: sv/rgd_channels.sv
// rgd_channels: valid/ready channel interfaces for pixel-pair requests,
// result words and register writes. Depends on rgd_pkg.
`default_nettype none

interface rgd_req_if import rgd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [RGB_WIDTH-1:0]   first_rgb;
   logic [RGB_WIDTH-1:0]   second_rgb;
   logic [COORD_WIDTH-1:0] pos_x;
   logic [COORD_WIDTH-1:0] pos_y;
   logic [BYTE_WIDTH-1:0]  old_byte;
   logic                   keep_first;
   logic                   keep_second;
   logic                   last_of_region;

   modport source (output valid, first_rgb, second_rgb, pos_x, pos_y, old_byte,
                   keep_first, keep_second, last_of_region, input ready);
   modport sink   (input valid, first_rgb, second_rgb, pos_x, pos_y, old_byte,
                   keep_first, keep_second, last_of_region, output ready);
endinterface

interface rgd_rsp_if import rgd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [BYTE_WIDTH-1:0]  new_byte;
   logic                   byte_changed;
   logic                   region_changed;
   logic [COORD_WIDTH-1:0] changed_x_min;
   logic [COORD_WIDTH-1:0] changed_x_max;
   logic [COORD_WIDTH-1:0] changed_y_min;
   logic [COORD_WIDTH-1:0] changed_y_max;

   modport source (output valid, new_byte, byte_changed, region_changed,
                   changed_x_min, changed_x_max, changed_y_min, changed_y_max,
                   input ready);
   modport sink   (input valid, new_byte, byte_changed, region_changed,
                   changed_x_min, changed_x_max, changed_y_min, changed_y_max,
                   output ready);
endinterface

interface rgd_csr_if import rgd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_IDX_WIDTH-1:0]  index;
   logic [CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/rgd_pixel_map.sv
// rgd_pixel_map: one pixel from RGB (or its kept old nibble) to a 4-bit
// output level under the current mode. Combinational. Depends on rgd_pkg.
`default_nettype none

module rgd_pixel_map import rgd_pkg::*; (
   input  logic [RGB_WIDTH-1:0]  rgb,
   input  logic                  keep,
   input  logic [GRAY_WIDTH-1:0] old_nibble,
   input  logic [1:0]            dither_x,
   input  logic [1:0]            dither_y,
   input  cfg_type               cfg,
   output logic [GRAY_WIDTH-1:0] level
);

   logic [31:0]           weighted;
   logic [GRAY_WIDTH-1:0] gray;
   logic [THR_WIDTH-1:0]  gray_ext;
   logic [GRAY_WIDTH-1:0] hi_level;
   logic [GRAY_WIDTH-1:0] lo_level;

   // constant-coefficient multiply; keep only the low 32 bits
   assign weighted = (({{(32-RGB_WIDTH){1'b0}}, rgb} & GRAY_MASK) * GRAY_MUL) + GRAY_ROUND;
   assign gray     = keep ? old_nibble : weighted[31 -: GRAY_WIDTH];
   assign gray_ext = {1'b0, gray};
   assign hi_level = cfg.invert ? LEVEL_BLACK : LEVEL_WHITE;
   assign lo_level = cfg.invert ? LEVEL_WHITE : LEVEL_BLACK;

   always_comb begin
      case (cfg.mode)
         MODE_PLAIN:  level = gray;
         MODE_DITHER: level = (gray >= DITHER_TAB[dither_x][dither_y]) ? hi_level : lo_level;
         MODE_THRESH: level = (gray_ext >= cfg.mono_threshold) ? hi_level : lo_level;
         MODE_TONES: begin
            if (gray_ext < cfg.tone_low)       level = LEVEL_BLACK;
            else if (gray_ext < cfg.tone_mid)  level = LEVEL_DARK;
            else if (gray_ext < cfg.tone_high) level = LEVEL_LIGHT;
            else                               level = LEVEL_WHITE;
         end
         default:     level = gray;
      endcase
   end

endmodule

`default_nettype wire

// File: sv/rgb_to_gray4_dither_pack.sv
// rgb_to_gray4_dither_pack: top level of the RGB pair to packed 4-bit gray
// converter with change tracking. Depends on rgd_pkg, rgd_channels, rgd_pixel_map.
`default_nettype none

// Each request word carries two RGB pixels, the x of the first (the second
// sits at x+1, wrapping within the coordinate width), the row, the current
// destination byte and keep flags for pixels outside the clip. The block
// returns the new packed byte, a changed flag, and on the word flagged
// last_of_region the bounding box of every changed pixel since the previous
// region end (all zero if nothing changed); the box then clears. The block
// takes one word per clock unless results stall; words pass the input register
// and the result register with the gray/mode logic between them. The box
// registers update as a word moves into the result register, so the next
// word already sees them. Register writes are always ready and take effect
// at once; write them only while no word is in flight.
module rgb_to_gray4_dither_pack import rgd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rgd_req_if.sink       req_chan,
   rgd_rsp_if.source     rsp_chan,
   rgd_csr_if.sink       csr_chan
);

   // configuration
   cfg_type cfg_ff;

   // input stage
   logic                   s1_valid_ff;
   logic [RGB_WIDTH-1:0]   s1_first_rgb_ff;
   logic [RGB_WIDTH-1:0]   s1_second_rgb_ff;
   logic [COORD_WIDTH-1:0] s1_pos_x_ff;
   logic [COORD_WIDTH-1:0] s1_pos_y_ff;
   logic [BYTE_WIDTH-1:0]  s1_old_byte_ff;
   logic                   s1_keep_first_ff;
   logic                   s1_keep_second_ff;
   logic                   s1_last_ff;

   // result stage
   logic                   out_valid_ff;
   logic [BYTE_WIDTH-1:0]  out_new_byte_ff;
   logic                   out_byte_changed_ff;
   logic                   out_region_changed_ff;
   logic [COORD_WIDTH-1:0] out_x_min_ff;
   logic [COORD_WIDTH-1:0] out_x_max_ff;
   logic [COORD_WIDTH-1:0] out_y_min_ff;
   logic [COORD_WIDTH-1:0] out_y_max_ff;

   // change box
   logic                   any_change_ff, any_change_in;
   logic [COORD_WIDTH-1:0] box_x_min_ff, box_x_min_in;
   logic [COORD_WIDTH-1:0] box_x_max_ff, box_x_max_in;
   logic [COORD_WIDTH-1:0] box_y_min_ff, box_y_min_in;
   logic [COORD_WIDTH-1:0] box_y_max_ff, box_y_max_in;

   logic out_free;
   logic s1_move;
   logic req_take;

   logic [COORD_WIDTH-1:0] x1;
   logic [1:0]             x1_low;
   logic [GRAY_WIDTH-1:0]  old_first;
   logic [GRAY_WIDTH-1:0]  old_second;
   logic [GRAY_WIDTH-1:0]  level_first;
   logic [GRAY_WIDTH-1:0]  level_second;
   logic [BYTE_WIDTH-1:0]  new_byte;
   logic [BYTE_WIDTH-1:0]  diff;
   logic                   diff_first;
   logic                   diff_second;
   logic [COORD_WIDTH-1:0] xmin;
   logic [COORD_WIDTH-1:0] xmax;
   logic                   upd_any;
   logic [COORD_WIDTH-1:0] upd_x_min;
   logic [COORD_WIDTH-1:0] upd_x_max;
   logic [COORD_WIDTH-1:0] upd_y_min;
   logic [COORD_WIDTH-1:0] upd_y_max;

   // handshakes: the result register frees when empty or being taken,
   // the input register frees when empty or moving on
   assign out_free          = !out_valid_ff || rsp_chan.ready;
   assign s1_move           = s1_valid_ff && out_free;
   assign req_chan.ready    = !s1_valid_ff || out_free;
   assign req_take          = req_chan.valid && req_chan.ready;
   assign csr_chan.ready    = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_PLAIN;
         cfg_ff.mono_threshold <= THR_WIDTH'(8);
         cfg_ff.invert         <= 1'b0;
         cfg_ff.tone_low       <= THR_WIDTH'(4);
         cfg_ff.tone_mid       <= THR_WIDTH'(8);
         cfg_ff.tone_high      <= THR_WIDTH'(12);
         cfg_ff.mirror_x       <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_MODE:      cfg_ff.mode           <= mode_type'(csr_chan.data[1:0]);
            CSR_BW_THR:    cfg_ff.mono_threshold <= csr_chan.data[THR_WIDTH-1:0];
            CSR_INVERT:    cfg_ff.invert         <= csr_chan.data[0];
            CSR_TONE_LOW:  cfg_ff.tone_low       <= csr_chan.data[THR_WIDTH-1:0];
            CSR_TONE_MID:  cfg_ff.tone_mid       <= csr_chan.data[THR_WIDTH-1:0];
            CSR_TONE_HIGH: cfg_ff.tone_high      <= csr_chan.data[THR_WIDTH-1:0];
            CSR_MIRROR_X:  cfg_ff.mirror_x       <= csr_chan.data[0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_first_rgb_ff   <= req_chan.first_rgb;
         s1_second_rgb_ff  <= req_chan.second_rgb;
         s1_pos_x_ff       <= req_chan.pos_x;
         s1_pos_y_ff       <= req_chan.pos_y;
         s1_old_byte_ff    <= req_chan.old_byte;
         s1_keep_first_ff  <= req_chan.keep_first;
         s1_keep_second_ff <= req_chan.keep_second;
         s1_last_ff        <= req_chan.last_of_region;
      end
   end

   // pixel mapping; the mirror setting picks which nibble each pixel owns
   assign x1         = s1_pos_x_ff + COORD_WIDTH'(1);
   assign x1_low     = x1[1:0];
   assign old_first  = cfg_ff.mirror_x ? s1_old_byte_ff[7:4] : s1_old_byte_ff[3:0];
   assign old_second = cfg_ff.mirror_x ? s1_old_byte_ff[3:0] : s1_old_byte_ff[7:4];

   rgd_pixel_map u_map_first (
      .rgb        (s1_first_rgb_ff),
      .keep       (s1_keep_first_ff),
      .old_nibble (old_first),
      .dither_x   (s1_pos_x_ff[1:0]),
      .dither_y   (s1_pos_y_ff[1:0]),
      .cfg        (cfg_ff),
      .level      (level_first)
   );

   rgd_pixel_map u_map_second (
      .rgb        (s1_second_rgb_ff),
      .keep       (s1_keep_second_ff),
      .old_nibble (old_second),
      .dither_x   (x1_low),
      .dither_y   (s1_pos_y_ff[1:0]),
      .cfg        (cfg_ff),
      .level      (level_second)
   );

   assign new_byte    = cfg_ff.mirror_x ? {level_first, level_second}
                                        : {level_second, level_first};
   assign diff        = new_byte ^ s1_old_byte_ff;
   assign diff_first  = cfg_ff.mirror_x ? (|diff[7:4]) : (|diff[3:0]);
   assign diff_second = cfg_ff.mirror_x ? (|diff[3:0]) : (|diff[7:4]);
   assign xmin        = diff_first  ? s1_pos_x_ff : x1;
   assign xmax        = diff_second ? x1 : s1_pos_x_ff;

   // grow the box with this word's changed pixels; rows arrive in scan
   // order, so the latest changed row becomes the bottom edge
   always_comb begin
      upd_any   = any_change_ff;
      upd_x_min = box_x_min_ff;
      upd_x_max = box_x_max_ff;
      upd_y_min = box_y_min_ff;
      upd_y_max = box_y_max_ff;
      if (diff != '0) begin
         upd_any = 1'b1;
         if (!any_change_ff) begin
            upd_x_min = xmin;
            upd_x_max = xmax;
            upd_y_min = s1_pos_y_ff;
            upd_y_max = s1_pos_y_ff;
         end else begin
            if (xmin < box_x_min_ff)        upd_x_min = xmin;
            if (xmax > box_x_max_ff)        upd_x_max = xmax;
            if (s1_pos_y_ff < box_y_min_ff) upd_y_min = s1_pos_y_ff;
            upd_y_max = s1_pos_y_ff;
         end
      end
   end

   // on the region's last word report, then clear
   always_comb begin
      any_change_in = any_change_ff;
      box_x_min_in  = box_x_min_ff;
      box_x_max_in  = box_x_max_ff;
      box_y_min_in  = box_y_min_ff;
      box_y_max_in  = box_y_max_ff;
      if (s1_move) begin
         if (s1_last_ff) begin
            any_change_in = 1'b0;
            box_x_min_in  = '0;
            box_x_max_in  = '0;
            box_y_min_in  = '0;
            box_y_max_in  = '0;
         end else begin
            any_change_in = upd_any;
            box_x_min_in  = upd_x_min;
            box_x_max_in  = upd_x_max;
            box_y_min_in  = upd_y_min;
            box_y_max_in  = upd_y_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_change_ff <= 1'b0;
         box_x_min_ff  <= '0;
         box_x_max_ff  <= '0;
         box_y_min_ff  <= '0;
         box_y_max_ff  <= '0;
      end else begin
         any_change_ff <= any_change_in;
         box_x_min_ff  <= box_x_min_in;
         box_x_max_ff  <= box_x_max_in;
         box_y_min_ff  <= box_y_min_in;
         box_y_max_ff  <= box_y_max_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_new_byte_ff     <= new_byte;
         out_byte_changed_ff <= (diff != '0);
         if (s1_last_ff && upd_any) begin
            out_region_changed_ff <= 1'b1;
            out_x_min_ff          <= upd_x_min;
            out_x_max_ff          <= upd_x_max;
            out_y_min_ff          <= upd_y_min;
            out_y_max_ff          <= upd_y_max;
         end else begin
            out_region_changed_ff <= 1'b0;
            out_x_min_ff          <= '0;
            out_x_max_ff          <= '0;
            out_y_min_ff          <= '0;
            out_y_max_ff          <= '0;
         end
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.new_byte       = out_new_byte_ff;
   assign rsp_chan.byte_changed   = out_byte_changed_ff;
   assign rsp_chan.region_changed = out_region_changed_ff;
   assign rsp_chan.changed_x_min  = out_x_min_ff;
   assign rsp_chan.changed_x_max  = out_x_max_ff;
   assign rsp_chan.changed_y_min  = out_y_min_ff;
   assign rsp_chan.changed_y_max  = out_y_max_ff;

endmodule

`default_nettype wire

// File: sim/rgb_to_gray4_dither_pack_checker.sv
// Watches the request, result and register channels of the RGB to 4-bit gray
// packer, predicts every result word and compares it field by field.
// Depends on rgd_pkg and rgd_channels.
module rgb_to_gray4_dither_pack_checker import rgd_pkg::*; (
   input  logic clock,
   input  logic reset,
   rgd_req_if   req_chan,
   rgd_rsp_if   rsp_chan,
   rgd_csr_if   csr_chan,
   output int   mismatches,
   output int   words_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam cfg_type CFG_AT_RESET = '{mode: MODE_PLAIN, mono_threshold: 5'd8, invert: 1'b0,
                                        tone_low: 5'd4, tone_mid: 5'd8, tone_high: 5'd12,
                                        mirror_x: 1'b0};

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  new_byte;
      logic                   byte_changed;
      logic                   region_changed;
      logic [COORD_WIDTH-1:0] x_min;
      logic [COORD_WIDTH-1:0] x_max;
      logic [COORD_WIDTH-1:0] y_min;
      logic [COORD_WIDTH-1:0] y_max;
   } merged_byte_type;

   cfg_type                cfg = CFG_AT_RESET;
   logic                   box_valid = 1'b0;
   logic [COORD_WIDTH-1:0] box_x_min = '0;
   logic [COORD_WIDTH-1:0] box_x_max = '0;
   logic [COORD_WIDTH-1:0] box_y_min = '0;
   logic [COORD_WIDTH-1:0] box_y_max = '0;
   merged_byte_type        bytes_due [$];
   int                     fail_total = 0;

   function automatic logic [GRAY_WIDTH-1:0] gray_level(input logic [RGB_WIDTH-1:0] rgb);
      logic [31:0] acc;
      acc = (32'(rgb) & GRAY_MASK) * GRAY_MUL + GRAY_ROUND;
      return acc[31:28];
   endfunction

   function automatic logic [GRAY_WIDTH-1:0] map_level(input logic [GRAY_WIDTH-1:0] g,
                                                       input logic [1:0] px,
                                                       input logic [1:0] py);
      logic [GRAY_WIDTH-1:0] hi, lo, lvl;
      hi = cfg.invert ? LEVEL_BLACK : LEVEL_WHITE;
      lo = cfg.invert ? LEVEL_WHITE : LEVEL_BLACK;
      case (cfg.mode)
         MODE_DITHER: lvl = (g >= DITHER_TAB[px][py]) ? hi : lo;
         MODE_THRESH: lvl = (g >= cfg.mono_threshold) ? hi : lo;
         MODE_TONES: begin
            // first test that holds wins, thresholds taken as written
            if (g < cfg.tone_low)       lvl = LEVEL_BLACK;
            else if (g < cfg.tone_mid)  lvl = LEVEL_DARK;
            else if (g < cfg.tone_high) lvl = LEVEL_LIGHT;
            else                        lvl = LEVEL_WHITE;
         end
         default: lvl = g;
      endcase
      return lvl;
   endfunction

   // Convert one pixel pair, merge into the old byte, advance the change box.
   function automatic merged_byte_type convert_pair(input logic [RGB_WIDTH-1:0]   rgb_a,
                                                    input logic [RGB_WIDTH-1:0]   rgb_b,
                                                    input logic [COORD_WIDTH-1:0] x_a,
                                                    input logic [COORD_WIDTH-1:0] y,
                                                    input logic [BYTE_WIDTH-1:0]  old,
                                                    input logic keep_a, keep_b, last);
      logic [COORD_WIDTH-1:0] x_b, x_lo, x_hi;
      logic [GRAY_WIDTH-1:0]  old_a, old_b, lvl_a, lvl_b;
      logic [BYTE_WIDTH-1:0]  diff;
      logic                   chg_a, chg_b;
      merged_byte_type        r;
      x_b   = x_a + 1'b1;
      old_a = cfg.mirror_x ? old[7:4] : old[3:0];
      old_b = cfg.mirror_x ? old[3:0] : old[7:4];
      // a kept pixel still goes through the mode mapping
      lvl_a = map_level(keep_a ? old_a : gray_level(rgb_a), x_a[1:0], y[1:0]);
      lvl_b = map_level(keep_b ? old_b : gray_level(rgb_b), x_b[1:0], y[1:0]);
      r = '0;
      r.new_byte     = cfg.mirror_x ? {lvl_a, lvl_b} : {lvl_b, lvl_a};
      diff           = r.new_byte ^ old;
      r.byte_changed = (diff != '0);
      chg_a = cfg.mirror_x ? (diff[7:4] != '0) : (diff[3:0] != '0);
      chg_b = cfg.mirror_x ? (diff[3:0] != '0) : (diff[7:4] != '0);
      if (r.byte_changed) begin
         x_lo = chg_a ? x_a : x_b;
         x_hi = chg_b ? x_b : x_a;
         if (!box_valid) begin
            box_x_min = x_lo;
            box_x_max = x_hi;
            box_y_min = y;
            box_y_max = y;
            box_valid = 1'b1;
         end else begin
            if (x_lo < box_x_min) box_x_min = x_lo;
            if (x_hi > box_x_max) box_x_max = x_hi;
            if (y < box_y_min) box_y_min = y;
            // the bottom edge follows the latest changed row
            box_y_max = y;
         end
      end
      if (last) begin
         if (box_valid) begin
            r.region_changed = 1'b1;
            r.x_min = box_x_min;
            r.x_max = box_x_max;
            r.y_min = box_y_min;
            r.y_max = box_y_max;
         end
         box_valid = 1'b0;
         box_x_min = '0;
         box_x_max = '0;
         box_y_min = '0;
         box_y_max = '0;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [COORD_WIDTH-1:0] want,
                                       input logic [COORD_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_total++;
      end
   endfunction

   always @(posedge clock) begin
      merged_byte_type got, want;
      if (reset) begin
         cfg       = CFG_AT_RESET;
         box_valid = 1'b0;
         box_x_min = '0;
         box_x_max = '0;
         box_y_min = '0;
         box_y_max = '0;
         bytes_due.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_index_type'(csr_chan.index))
               CSR_MODE:      cfg.mode           = mode_type'(csr_chan.data[1:0]);
               CSR_BW_THR:    cfg.mono_threshold = csr_chan.data[THR_WIDTH-1:0];
               CSR_INVERT:    cfg.invert         = csr_chan.data[0];
               CSR_TONE_LOW:  cfg.tone_low       = csr_chan.data[THR_WIDTH-1:0];
               CSR_TONE_MID:  cfg.tone_mid       = csr_chan.data[THR_WIDTH-1:0];
               CSR_TONE_HIGH: cfg.tone_high      = csr_chan.data[THR_WIDTH-1:0];
               CSR_MIRROR_X:  cfg.mirror_x       = csr_chan.data[0];
               default: ;
            endcase
         end
         // compare before pushing, so a word leaving this edge never meets its own request
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{new_byte: rsp_chan.new_byte, byte_changed: rsp_chan.byte_changed,
                    region_changed: rsp_chan.region_changed,
                    x_min: rsp_chan.changed_x_min, x_max: rsp_chan.changed_x_max,
                    y_min: rsp_chan.changed_y_min, y_max: rsp_chan.changed_y_max};
            if (bytes_due.size() == 0) begin
               $error("result word arrived with no request outstanding");
               fail_total++;
            end else begin
               want = bytes_due.pop_front();
               check_field("new_byte",       want.new_byte,       got.new_byte);
               check_field("byte_changed",   want.byte_changed,   got.byte_changed);
               check_field("region_changed", want.region_changed, got.region_changed);
               check_field("changed_x_min",  want.x_min,          got.x_min);
               check_field("changed_x_max",  want.x_max,          got.x_max);
               check_field("changed_y_min",  want.y_min,          got.y_min);
               check_field("changed_y_max",  want.y_max,          got.y_max);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            bytes_due.push_back(convert_pair(req_chan.first_rgb, req_chan.second_rgb,
                                             req_chan.pos_x, req_chan.pos_y, req_chan.old_byte,
                                             req_chan.keep_first, req_chan.keep_second,
                                             req_chan.last_of_region));
         end
      end
      words_due  <= bytes_due.size();
      mismatches <= fail_total;
   end

endmodule

// File: sim/rgb_to_gray4_dither_pack_tb.sv
// Top of the RGB to 4-bit gray packer bench: clock, reset, stimulus and verdict.
// Depends on rgd_pkg, rgd_channels, the block and rgb_to_gray4_dither_pack_checker.
module rgb_to_gray4_dither_pack_tb import rgd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_PCT       = 28;      // chance in a hundred of an idle cycle
   localparam int PHASES          = 10;
   localparam int PAIRS_PER_PHASE = 85;
   localparam int SETTLE_CYCLES   = 4;       // input and result registers plus margin
   localparam int CYCLE_LIMIT     = 100000;
   localparam int CALM_PHASE      = 4;       // phase run with both sides never idling

   logic clock = 1'b0;
   logic reset;
   logic steady_run = 1'b0;
   int   cycle_count = 0;
   int   pairs_sent = 0;
   int   mismatches;
   int   words_due;

   rgd_req_if req_chan ();
   rgd_rsp_if rsp_chan ();
   rgd_csr_if csr_chan ();

   rgb_to_gray4_dither_pack u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   rgb_to_gray4_dither_pack_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan),
      .mismatches (mismatches),
      .words_due  (words_due)
   );

   always #5 clock = ~clock;

   // Stall the result side at random, except during the calm phase.
   always @(posedge clock) begin
      rsp_chan.ready <= steady_run || ($urandom_range(0, 99) >= STALL_PCT);
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Mostly random pixels, with black, white and neutral grays mixed in.
   function automatic logic [RGB_WIDTH-1:0] rand_rgb();
      logic [RGB_WIDTH-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = '0;
         1:       v = '1;
         2:       v = {3{8'($urandom)}};
         default: v = RGB_WIDTH'($urandom);
      endcase
      return v;
   endfunction

   // Old bytes often already hold black/white nibbles, so unchanged bytes show up.
   function automatic logic [BYTE_WIDTH-1:0] rand_old();
      logic [BYTE_WIDTH-1:0] v;
      case ($urandom_range(0, 5))
         0:       v = 8'h00;
         1:       v = 8'hff;
         2:       v = 8'h0f;
         3:       v = 8'hf0;
         default: v = BYTE_WIDTH'($urandom);
      endcase
      return v;
   endfunction

   // Offer one pixel-pair word and hold it until it is taken.
   task automatic send_pair(input logic [RGB_WIDTH-1:0] rgb_a, input logic [RGB_WIDTH-1:0] rgb_b,
                            input logic [COORD_WIDTH-1:0] x, input logic [COORD_WIDTH-1:0] y,
                            input logic [BYTE_WIDTH-1:0] old,
                            input logic keep_a, input logic keep_b, input logic last);
      while (!steady_run && $urandom_range(0, 99) < STALL_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.first_rgb      <= rgb_a;
      req_chan.second_rgb     <= rgb_b;
      req_chan.pos_x          <= x;
      req_chan.pos_y          <= y;
      req_chan.old_byte       <= old;
      req_chan.keep_first     <= keep_a;
      req_chan.keep_second    <= keep_b;
      req_chan.last_of_region <= last;
      do @(posedge clock); while (!req_chan.ready);
      pairs_sent++;
   endtask

   // Walk a rectangle row by row, at random clipped on either side, ending on its last pair.
   task automatic send_region();
      int                     cols, rows;
      logic [COORD_WIDTH-1:0] x0, y0;
      logic                   clip_l, clip_r;
      cols   = $urandom_range(1, 6);
      rows   = $urandom_range(1, 4);
      // now and then start near the right edge so x can wrap inside the region
      if ($urandom_range(0, 7) == 0) x0 = COORD_WIDTH'(4094 - 2 * $urandom_range(0, 3));
      else                           x0 = COORD_WIDTH'(2 * $urandom_range(0, 2047));
      y0     = COORD_WIDTH'($urandom);
      clip_l = ($urandom_range(0, 3) == 0);
      clip_r = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            send_pair(rand_rgb(), rand_rgb(), x0 + COORD_WIDTH'(2 * c), y0 + COORD_WIDTH'(r),
                      rand_old(), clip_l && c == 0, clip_r && c == cols - 1,
                      r == rows - 1 && c == cols - 1);
         end
      end
   endtask

   // Wait for every result word, then let the pipe settle.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all seven registers back to back, valid held high between words.
   task automatic program_regs(input cfg_type c);
      csr_index_type             idx;
      logic [CSR_DATA_WIDTH-1:0] val;
      idx = idx.first();
      repeat (idx.num()) begin
         case (idx)
            CSR_MODE:      val = CSR_DATA_WIDTH'(c.mode);
            CSR_BW_THR:    val = CSR_DATA_WIDTH'(c.mono_threshold);
            CSR_INVERT:    val = CSR_DATA_WIDTH'(c.invert);
            CSR_TONE_LOW:  val = CSR_DATA_WIDTH'(c.tone_low);
            CSR_TONE_MID:  val = CSR_DATA_WIDTH'(c.tone_mid);
            CSR_TONE_HIGH: val = CSR_DATA_WIDTH'(c.tone_high);
            CSR_MIRROR_X:  val = CSR_DATA_WIDTH'(c.mirror_x);
            default:       val = '0;
         endcase
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx;
         csr_chan.data  <= val;
         do @(posedge clock); while (!csr_chan.ready);
         idx = idx.next();
      end
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      cfg_type plan [0:PHASES-1];
      int      target;

      // drive every input to a known value before the first edge
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.first_rgb      = '0;
      req_chan.second_rgb     = '0;
      req_chan.pos_x          = '0;
      req_chan.pos_y          = '0;
      req_chan.old_byte       = '0;
      req_chan.keep_first     = 1'b0;
      req_chan.keep_second    = 1'b0;
      req_chan.last_of_region = 1'b0;
      rsp_chan.ready          = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.index          = CSR_MODE;
      csr_chan.data           = '0;

      // settings per phase: both black/white modes with and without invert and mirror,
      // threshold extremes, tones in and out of order, plain gray, then two random mixes
      plan[0] = '{mode: MODE_DITHER, mono_threshold: 5'd8,  invert: 1'b0, tone_low: 5'd4,
                  tone_mid: 5'd8,  tone_high: 5'd12, mirror_x: 1'b0};
      plan[1] = '{mode: MODE_DITHER, mono_threshold: 5'd8,  invert: 1'b1, tone_low: 5'd4,
                  tone_mid: 5'd8,  tone_high: 5'd12, mirror_x: 1'b1};
      plan[2] = '{mode: MODE_THRESH, mono_threshold: 5'd0,  invert: 1'b0, tone_low: 5'd0,
                  tone_mid: 5'd0,  tone_high: 5'd0,  mirror_x: 1'b0};
      plan[3] = '{mode: MODE_THRESH, mono_threshold: 5'd16, invert: 1'b1, tone_low: 5'd16,
                  tone_mid: 5'd16, tone_high: 5'd16, mirror_x: 1'b1};
      plan[4] = '{mode: MODE_TONES,  mono_threshold: 5'd7,  invert: 1'b0, tone_low: 5'd4,
                  tone_mid: 5'd8,  tone_high: 5'd12, mirror_x: 1'b0};
      plan[5] = '{mode: MODE_TONES,  mono_threshold: 5'd7,  invert: 1'b1, tone_low: 5'd12,
                  tone_mid: 5'd4,  tone_high: 5'd16, mirror_x: 1'b1};
      plan[6] = '{mode: MODE_TONES,  mono_threshold: 5'd9,  invert: 1'b0, tone_low: 5'd0,
                  tone_mid: 5'd16, tone_high: 5'd16, mirror_x: 1'b0};
      plan[7] = '{mode: MODE_PLAIN,  mono_threshold: 5'd15, invert: 1'b1, tone_low: 5'd3,
                  tone_mid: 5'd9,  tone_high: 5'd14, mirror_x: 1'b1};
      for (int i = 8; i < PHASES; i++) begin
         plan[i] = '{mode: mode_type'($urandom_range(0, 3)),
                     mono_threshold: THR_WIDTH'($urandom_range(0, 16)),
                     invert: 1'($urandom_range(0, 1)),
                     tone_low: THR_WIDTH'($urandom_range(0, 16)),
                     tone_mid: THR_WIDTH'($urandom_range(0, 16)),
                     tone_high: THR_WIDTH'($urandom_range(0, 16)),
                     mirror_x: 1'($urandom_range(0, 1))};
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset settings (plain gray, low nibble first).
      // black on black: nothing changes
      send_pair(24'h000000, 24'h000000, 12'd0, 12'd0, 8'h00, 1'b0, 1'b0, 1'b0);
      // region end with no change: box stays all zero
      send_pair(24'h000000, 24'h000000, 12'd0, 12'd0, 8'h00, 1'b0, 1'b0, 1'b1);
      // white pair at the far corner
      send_pair(24'hffffff, 24'hffffff, 12'd4094, 12'd4095, 8'h00, 1'b0, 1'b0, 1'b0);
      // odd x at the top edge: second pixel wraps to x 0; report the box
      send_pair(24'hffffff, 24'h000000, 12'd4095, 12'd0, 8'hff, 1'b0, 1'b0, 1'b1);
      // both pixels kept: byte comes back untouched
      send_pair(24'hffffff, 24'hffffff, 12'd10, 12'd20, 8'ha5, 1'b1, 1'b1, 1'b1);
      // keep only the first pixel, then only the second
      send_pair(24'hffffff, 24'h000000, 12'd2, 12'd3, 8'hff, 1'b1, 1'b0, 1'b0);
      send_pair(24'h000000, 24'hffffff, 12'd6, 12'd1, 8'h3c, 1'b0, 1'b1, 1'b0);
      // primaries and colors whose low bits are masked off
      send_pair(24'hff0000, 24'h00ff00, 12'd8, 12'd2, 8'h00, 1'b0, 1'b0, 1'b0);
      send_pair(24'h0000ff, 24'h070707, 12'd12, 12'd2, 8'hff, 1'b0, 1'b0, 1'b0);
      send_pair(24'h808080, 24'h7f7f7f, 12'd2048, 12'd2048, 8'h77, 1'b0, 1'b0, 1'b0);
      send_pair(24'h123456, 24'hfedcba, 12'd2, 12'd4094, 8'h5a, 1'b0, 1'b0, 1'b1);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         steady_run <= (ph == CALM_PHASE);
         program_regs(plan[ph]);
         // mostly walked regions, with a share of scattered noise words
         target = pairs_sent + PAIRS_PER_PHASE;
         while (pairs_sent < target) begin
            if ($urandom_range(0, 9) < 8) begin
               send_region();
            end else begin
               send_pair(rand_rgb(), rand_rgb(), COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
                         BYTE_WIDTH'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
            end
         end
      end

      drain();
      if (mismatches == 0 && words_due == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
